/* sv/assert_macros.svh */
// assertion macros used by the top level rtl file of the block cipher
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, disabled while reset is high
`define SPN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property that also holds across reset
`define SPN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPN_ASSERT(lbl, clk, rst, prop, msg)
`define SPN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/spnbc_pkg.sv */
// types, constants and round functions of the 128-bit spn block cipher
// no dependencies; used by the channel interfaces and all modules
package spnbc_pkg;

   localparam int HALF_W         = 64;
   localparam int BLOCK_W        = 2 * HALF_W;
   localparam int NIBBLES        = BLOCK_W / 4;
   localparam int ROUNDS_DEFAULT = 35;
   localparam int RC_COUNT       = 35;
   localparam int TAP_COUNT      = 6;
   localparam int CSR_INDEX_W    = 1;

   typedef logic [BLOCK_W-1:0] block_type;

   typedef struct packed {
      logic valid;
      logic mode;
   } stage_ctl_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_LOW  = 1'b0,
      CSR_KEY_HIGH = 1'b1
   } csr_index_type;

   localparam logic MODE_ENC = 1'b0;

   localparam block_type KEY_NIBBLE_MASK = {NIBBLES{4'hD}};

   localparam logic [3:0] SBOX_FWD [16] = '{
      4'd3, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd8, 4'd14,
      4'd12, 4'd15, 4'd9, 4'd2, 4'd4, 4'd10, 4'd7, 4'd1
   };

   localparam logic [3:0] SBOX_INV [16] = '{
      4'd1, 4'd15, 4'd11, 4'd0, 4'd12, 4'd5, 4'd2, 4'd14,
      4'd6, 4'd10, 4'd13, 4'd4, 4'd8, 4'd3, 4'd7, 4'd9
   };

   localparam logic [6:0] TAPS [TAP_COUNT] = '{
      7'd8, 7'd13, 7'd19, 7'd35, 7'd67, 7'd106
   };

   localparam logic [5:0] RCONST [RC_COUNT] = '{
      6'd2, 6'd33, 6'd16, 6'd9, 6'd36, 6'd19, 6'd40, 6'd53, 6'd26, 6'd13,
      6'd38, 6'd51, 6'd56, 6'd61, 6'd62, 6'd31, 6'd14, 6'd7, 6'd34, 6'd49,
      6'd24, 6'd45, 6'd54, 6'd59, 6'd28, 6'd47, 6'd22, 6'd43, 6'd20, 6'd11,
      6'd4, 6'd3, 6'd32, 6'd17, 6'd8
   };

   localparam logic [6:0] PERM [BLOCK_W] = '{
      7'd0, 7'd33, 7'd66, 7'd99, 7'd96, 7'd1, 7'd34, 7'd67,
      7'd64, 7'd97, 7'd2, 7'd35, 7'd32, 7'd65, 7'd98, 7'd3,
      7'd4, 7'd37, 7'd70, 7'd103, 7'd100, 7'd5, 7'd38, 7'd71,
      7'd68, 7'd101, 7'd6, 7'd39, 7'd36, 7'd69, 7'd102, 7'd7,
      7'd8, 7'd41, 7'd74, 7'd107, 7'd104, 7'd9, 7'd42, 7'd75,
      7'd72, 7'd105, 7'd10, 7'd43, 7'd40, 7'd73, 7'd106, 7'd11,
      7'd12, 7'd45, 7'd78, 7'd111, 7'd108, 7'd13, 7'd46, 7'd79,
      7'd76, 7'd109, 7'd14, 7'd47, 7'd44, 7'd77, 7'd110, 7'd15,
      7'd16, 7'd49, 7'd82, 7'd115, 7'd112, 7'd17, 7'd50, 7'd83,
      7'd80, 7'd113, 7'd18, 7'd51, 7'd48, 7'd81, 7'd114, 7'd19,
      7'd20, 7'd53, 7'd86, 7'd119, 7'd116, 7'd21, 7'd54, 7'd87,
      7'd84, 7'd117, 7'd22, 7'd55, 7'd52, 7'd85, 7'd118, 7'd23,
      7'd24, 7'd57, 7'd90, 7'd123, 7'd120, 7'd25, 7'd58, 7'd91,
      7'd88, 7'd121, 7'd26, 7'd59, 7'd56, 7'd89, 7'd122, 7'd27,
      7'd28, 7'd61, 7'd94, 7'd127, 7'd124, 7'd29, 7'd62, 7'd95,
      7'd92, 7'd125, 7'd30, 7'd63, 7'd60, 7'd93, 7'd126, 7'd31
   };

   // s-box on every nibble
   function automatic block_type sub_all(input block_type x, input logic inverse);
      block_type r;
      r = '0;
      for (int n = 0; n < NIBBLES; n++) begin
         r[4*n +: 4] = inverse ? SBOX_INV[x[4*n +: 4]] : SBOX_FWD[x[4*n +: 4]];
      end
      return r;
   endfunction

   // bit i goes to PERM[i]
   function automatic block_type perm_fwd(input block_type x);
      block_type r;
      r = '0;
      for (int i = 0; i < BLOCK_W; i++) begin
         r[PERM[i]] = x[i];
      end
      return r;
   endfunction

   // bit PERM[i] comes back to i
   function automatic block_type perm_inv(input block_type x);
      block_type r;
      r = '0;
      for (int i = 0; i < BLOCK_W; i++) begin
         r[i] = x[PERM[i]];
      end
      return r;
   endfunction

   // round constant bits onto the taps, zero past the table
   function automatic block_type add_const(input block_type x, input int idx);
      logic [5:0] c;
      block_type  r;
      c = '0;
      if (idx >= 0 && idx < RC_COUNT) begin
         c = RCONST[idx];
      end
      r = x;
      for (int b = 0; b < TAP_COUNT; b++) begin
         r[TAPS[b]] = r[TAPS[b]] ^ c[b];
      end
      return r;
   endfunction

   // rotate right by a fixed amount below the block width
   function automatic block_type rotr(input block_type x, input int unsigned n);
      logic [2*BLOCK_W-1:0] d;
      d = {x, x} >> n;
      return d[BLOCK_W-1:0];
   endfunction

endpackage

/* sv/spnbc_channels.sv */
// valid/ready channel interfaces for requests and results
// depends on spnbc_pkg for the field widths
interface spnbc_req_if;
   import spnbc_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [HALF_W-1:0] block_low;
   logic [HALF_W-1:0] block_high;
   modport source (output valid, output mode, output block_low, output block_high,
                   input ready);
   modport sink (input valid, input mode, input block_low, input block_high,
                 output ready);
endinterface

interface spnbc_rsp_if;
   import spnbc_pkg::*;
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] result_low;
   logic [HALF_W-1:0] result_high;
   modport source (output valid, output result_low, output result_high, input ready);
   modport sink (input valid, input result_low, input result_high, output ready);
endinterface

/* sv/spn_block_cipher_128_enc_dec.sv */
// top level of the 128-bit spn block cipher, encrypt and decrypt
// depends on spnbc_pkg, spnbc_channels, spnbc_csr, spnbc_stage, assert_macros.svh
//
// Encrypts or decrypts one 128-bit block per request under the 128-bit key
// held in two 64-bit csr registers (index 0 key bits 0..63, index 1 key bits
// 64..127, both reset to zero). Each request carries a mode bit (0 encrypt,
// 1 decrypt) and the block as low and high 64-bit halves; exactly one result
// comes back per request, in request order. The datapath is an unrolled
// pipeline with one cipher round per register stage, ROUNDS stages in all.
// The first stage register loads at the edge that accepts the request, and
// the block then moves through the stage registers in order to the output
// register. A new request can be accepted every cycle unless a stalled
// result has backed the pipeline up. Encrypt and decrypt requests may
// be mixed freely since the mode travels down the pipeline with its block.
// The last stage register is the output register; each stage holds its
// block while the stage below it is full and stalled, and an empty stage
// keeps taking data, so gaps close up behind a stalled result. The key is
// read live by every stage: write it only while no request is in flight.
`include "assert_macros.svh"
module spn_block_cipher_128_enc_dec #(
   parameter int ROUNDS = spnbc_pkg::ROUNDS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   spnbc_req_if.sink                         req_ch,
   spnbc_rsp_if.source                       rsp_ch,
   input  logic                              csr_we,
   input  logic [spnbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [spnbc_pkg::HALF_W-1:0]      csr_wdata
);
   import spnbc_pkg::*;

   block_type     key;
   // entry i feeds stage i; entry ROUNDS is the output register
   stage_ctl_type ctl  [ROUNDS+1];
   block_type     data [ROUNDS+1];
   logic          rdy  [ROUNDS+1];

   // key registers
   spnbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .key       (key)
   );

   // request side feeds the first round
   assign ctl[0].valid = req_ch.valid;
   assign ctl[0].mode  = req_ch.mode;
   assign data[0]      = {req_ch.block_high, req_ch.block_low};
   assign req_ch.ready = rdy[0];

   // one round per stage
   for (genvar i = 0; i < ROUNDS; i++) begin : g_round
      spnbc_stage #(
         .ROUNDS    (ROUNDS),
         .ROUND_IDX (i)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .key        (key),
         .up_ctl     (ctl[i]),
         .up_data    (data[i]),
         .up_ready   (rdy[i]),
         .down_ctl   (ctl[i+1]),
         .down_data  (data[i+1]),
         .down_ready (rdy[i+1])
      );
   end

   // result side taken from the last stage register
   assign rdy[ROUNDS]        = rsp_ch.ready;
   assign rsp_ch.valid       = ctl[ROUNDS].valid;
   assign rsp_ch.result_low  = data[ROUNDS][HALF_W-1:0];
   assign rsp_ch.result_high = data[ROUNDS][BLOCK_W-1:HALF_W];

   // an accepted request is in the first stage register in the next cycle
   `SPN_ASSERT(a_accept_lands, clock, reset, req_ch.valid && req_ch.ready |=> ctl[1].valid, "accepted request missing from first stage")
   // a full first stage that cannot pass on keeps its block
   `SPN_ASSERT(a_stage_hold, clock, reset, ctl[1].valid && !rdy[1] |=> $stable(data[1]) && ctl[1].valid, "stalled first stage lost its block")
   // an empty output register means the whole chain can take data
   `SPN_ASSERT(a_ready_chain, clock, reset, !rsp_ch.valid |-> req_ch.ready, "pipeline blocked with empty output register")
   // no result straight after reset
   `SPN_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_ch.valid, "result valid after reset")

endmodule

/* sv/spnbc_csr.sv */
// key register pair written through the plain csr write port
// depends on spnbc_pkg
module spnbc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [spnbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [spnbc_pkg::HALF_W-1:0]      csr_wdata,
   output spnbc_pkg::block_type              key
);
   import spnbc_pkg::*;

   logic [HALF_W-1:0] key_low_ff, key_low_in;
   logic [HALF_W-1:0] key_high_ff, key_high_in;

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_LOW:  key_low_in  = csr_wdata;
            CSR_KEY_HIGH: key_high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
      end
   end

   assign key = {key_high_ff, key_low_ff};

endmodule

/* sv/spnbc_stage.sv */
// one pipeline stage: a single encrypt or decrypt round and its register
// depends on spnbc_pkg
module spnbc_stage #(
   parameter int ROUNDS    = spnbc_pkg::ROUNDS_DEFAULT,
   parameter int ROUND_IDX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spnbc_pkg::block_type     key,
   input  spnbc_pkg::stage_ctl_type up_ctl,
   input  spnbc_pkg::block_type     up_data,
   output logic                     up_ready,
   output spnbc_pkg::stage_ctl_type down_ctl,
   output spnbc_pkg::block_type     down_data,
   input  logic                     down_ready
);
   import spnbc_pkg::*;

   localparam int unsigned ENC_ROT = ROUND_IDX + 1;
   localparam int unsigned DEC_ROT = ROUNDS - ROUND_IDX;
   localparam int          DEC_RC  = ROUNDS - 1 - ROUND_IDX;

   stage_ctl_type ctl_ff, ctl_in;
   block_type     data_ff, data_in;
   block_type     enc_t, dec_t;

   always_comb begin
      // forward round, whitening ahead of the first one
      enc_t = up_data;
      if (ROUND_IDX == 0) begin
         enc_t = enc_t ^ key;
      end
      enc_t = sub_all(enc_t, 1'b0);
      enc_t = perm_fwd(enc_t);
      enc_t = add_const(enc_t, ROUND_IDX);
      enc_t = enc_t ^ (rotr(key, ENC_ROT) & KEY_NIBBLE_MASK);

      // inverse round, whitening after the last one
      dec_t = up_data ^ (rotr(key, DEC_ROT) & KEY_NIBBLE_MASK);
      dec_t = add_const(dec_t, DEC_RC);
      dec_t = perm_inv(dec_t);
      dec_t = sub_all(dec_t, 1'b1);
      if (ROUND_IDX == ROUNDS - 1) begin
         dec_t = dec_t ^ key;
      end
   end

   assign up_ready = !ctl_ff.valid || down_ready;

   always_comb begin
      ctl_in  = ctl_ff;
      data_in = data_ff;
      if (up_ready) begin
         ctl_in  = up_ctl;
         data_in = (up_ctl.mode == MODE_ENC) ? enc_t : dec_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign down_ctl  = ctl_ff;
   assign down_data = data_ff;

endmodule

/* dv/spn_block_cipher_128_enc_dec_tb.sv */
// self-checking testbench for the 128-bit spn block cipher, encrypt and decrypt
// depends on spnbc_pkg, spnbc_channels and the spn_block_cipher_128_enc_dec rtl
module spn_block_cipher_128_enc_dec_tb;
   import spnbc_pkg::*;

   localparam int CIPHER_ROUNDS = 35;
   localparam logic MODE_DEC = !MODE_ENC;

   // s-box tables, one nibble per table entry, entry 0 in the low nibble
   localparam logic [63:0] SBOX_FWD_NIB = 64'h17A429FCE85BD603;
   localparam logic [63:0] SBOX_INV_NIB = 64'h97384DA6E25C0BF1;
   localparam block_type NIB_KEY_MASK = {32{4'hD}};

   localparam logic [5:0] RC_TABLE [35] = '{
      6'd2, 6'd33, 6'd16, 6'd9, 6'd36, 6'd19, 6'd40, 6'd53, 6'd26, 6'd13,
      6'd38, 6'd51, 6'd56, 6'd61, 6'd62, 6'd31, 6'd14, 6'd7, 6'd34, 6'd49,
      6'd24, 6'd45, 6'd54, 6'd59, 6'd28, 6'd47, 6'd22, 6'd43, 6'd20, 6'd11,
      6'd4, 6'd3, 6'd32, 6'd17, 6'd8
   };
   localparam int TAP_POS [6] = '{8, 13, 19, 35, 67, 106};

   // idle rate in percent, random items per key setting, long ready hold length
   localparam int IDLE_PCT     = 36;
   localparam int PHASE_ITEMS  = 210;
   localparam int KEY_PHASES   = 8;
   localparam int HOLD_CYCLES  = 150;
   localparam int MAX_REPORTS  = 100;

   typedef struct packed {
      logic        mode;
      logic [63:0] high;
      logic [63:0] low;
   } block_request_t;

   logic clock;
   logic reset = 1'b1;

   // tb-side copies of every block input, known from time zero
   logic              req_valid = 1'b0;
   logic              req_mode  = MODE_ENC;
   logic [63:0]       req_low   = '0;
   logic [63:0]       req_high  = '0;
   logic              rsp_ready = 1'b0;
   logic              csr_we    = 1'b0;
   csr_index_type     csr_index = CSR_KEY_LOW;
   logic [63:0]       csr_wdata = '0;

   spnbc_req_if req_ch ();
   spnbc_rsp_if rsp_ch ();

   assign req_ch.valid      = req_valid;
   assign req_ch.mode       = req_mode;
   assign req_ch.block_low  = req_low;
   assign req_ch.block_high = req_high;
   assign rsp_ch.ready      = rsp_ready;

   spn_block_cipher_128_enc_dec #(
      .ROUNDS (CIPHER_ROUNDS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // key as the block holds it, mirrored on every csr write
   logic [63:0] key_low_now  = '0;
   logic [63:0] key_high_now = '0;

   block_request_t pending_requests [$];
   block_type      cipher_outputs_due [$];

   int  accepted_cnt = 0;
   int  mismatch_cnt = 0;
   bit  req_fire     = 1'b0;
   int  hold_left    = 0;
   int  holds_done   = 0;

   // both sides stop idling for a stretch of the run
   wire steady_window = accepted_cnt >= 700 && accepted_cnt < 1000;

   // ---------------------------------------------------------------------
   // cipher prediction
   // ---------------------------------------------------------------------

   // 4-bit s-box on all 32 nibbles
   function automatic block_type sbox_layer(input block_type x, input bit inverse);
      block_type   r;
      logic [63:0] tbl;
      tbl = inverse ? SBOX_INV_NIB : SBOX_FWD_NIB;
      for (int n = 0; n < 32; n++) begin
         r[4*n +: 4] = tbl[4*x[4*n +: 4] +: 4];
      end
      return r;
   endfunction

   // bit i = 16g + 4j + b goes to 32*((b - j) mod 4) + 4g + b
   function automatic block_type bit_layer(input block_type x, input bit inverse);
      block_type r;
      int        dst;
      r = '0;
      for (int i = 0; i < 128; i++) begin
         dst = 32 * (((i % 4) - ((i / 4) % 4)) & 3) + 4 * (i / 16) + (i % 4);
         if (inverse) begin
            r[i] = x[dst];
         end else begin
            r[dst] = x[i];
         end
      end
      return r;
   endfunction

   // six round-constant bits onto their taps, nothing past the table
   function automatic block_type round_const(input block_type x, input int rnd);
      block_type  r;
      logic [5:0] rc;
      rc = (rnd >= 0 && rnd < 35) ? RC_TABLE[rnd] : 6'd0;
      r = x;
      for (int b = 0; b < 6; b++) begin
         r[TAP_POS[b]] = r[TAP_POS[b]] ^ rc[b];
      end
      return r;
   endfunction

   function automatic block_type spn_cipher(input logic mode, input block_type blk,
                                            input block_type key);
      block_type s;
      block_type k;
      s = blk;
      k = key;
      if (mode == MODE_ENC) begin
         s = s ^ k;
         for (int r = 0; r < CIPHER_ROUNDS; r++) begin
            s = sbox_layer(s, 1'b0);
            s = bit_layer(s, 1'b0);
            s = round_const(s, r);
            k = {k[0], k[127:1]};
            s = s ^ (k & NIB_KEY_MASK);
         end
      end else begin
         // start from the key as it stands after the last encrypt round
         for (int r = 0; r < CIPHER_ROUNDS; r++) begin
            k = {k[0], k[127:1]};
         end
         for (int r = 0; r < CIPHER_ROUNDS; r++) begin
            s = s ^ (k & NIB_KEY_MASK);
            k = {k[126:0], k[127]};
            s = round_const(s, CIPHER_ROUNDS - 1 - r);
            s = bit_layer(s, 1'b1);
            s = sbox_layer(s, 1'b1);
         end
         s = s ^ k;
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // clock, checking helpers
   // ---------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS) begin
         $display("%0t: %s: got %h, want %h", $time, what, got, want);
      end
   endtask

   // mostly random halves, now and then all zeros or all ones
   function automatic logic [63:0] pick_half();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic queue_request(input logic mode, input logic [63:0] high,
                                input logic [63:0] low);
      block_request_t item;
      item.mode = mode;
      item.high = high;
      item.low  = low;
      pending_requests.push_back(item);
   endtask

   // csr write at a falling edge, taken at the next rising edge
   task automatic write_key(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_KEY_LOW:  key_low_now  = value;
         CSR_KEY_HIGH: key_high_now = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // block is idle once nothing is queued, offered or still owed
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || cipher_outputs_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // request driver: holds an offered request until taken, then maybe idles
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_requests.size() != 0 &&
             (steady_window || $urandom_range(99) >= IDLE_PCT)) begin
            block_request_t nxt;
            nxt = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_mode  <= nxt.mode;
            req_low   <= nxt.low;
            req_high  <= nxt.high;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // result receiver: random stalls plus two long holds that back the
   // pipeline up into the request side
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_left == 0 && holds_done < 2 && accepted_cnt >= 280 + 840 * holds_done) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_window || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predict on every accepted request, check every result in order
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      block_type want;
      req_fire = !reset && req_ch.valid && req_ch.ready;
      if (req_fire) begin
         cipher_outputs_due.push_back(spn_cipher(req_ch.mode,
                                                 {req_ch.block_high, req_ch.block_low},
                                                 {key_high_now, key_low_now}));
         accepted_cnt++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (cipher_outputs_due.size() == 0) begin
            report_mismatch("result with no request outstanding",
                            rsp_ch.result_low, '0);
         end else begin
            want = cipher_outputs_due.pop_front();
            if (rsp_ch.result_low !== want[63:0]) begin
               report_mismatch("result_low", rsp_ch.result_low, want[63:0]);
            end
            if (rsp_ch.result_high !== want[127:64]) begin
               report_mismatch("result_high", rsp_ch.result_high, want[127:64]);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   initial begin
      logic           md;
      block_type      pt;
      block_type      ct;
      logic [63:0]    klo;
      logic [63:0]    khi;
      block_request_t last_req;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed requests under the reset key of zero
      for (int m = 0; m < 2; m++) begin
         md = (m == 0) ? MODE_ENC : MODE_DEC;
         queue_request(md, '0, '0);
         queue_request(md, '1, '1);
         queue_request(md, '0, 64'h1);
         queue_request(md, 64'h8000_0000_0000_0000, '0);
         queue_request(md, {16{4'h5}}, {16{4'h5}});
         queue_request(md, {16{4'hA}}, {16{4'hA}});
         queue_request(md, '0, '1);
         queue_request(md, '1, '0);
      end
      // round trips: decrypt of a real ciphertext, encrypt of a real plaintext
      pt = {$urandom, $urandom, $urandom, $urandom};
      ct = spn_cipher(MODE_ENC, pt, '0);
      queue_request(MODE_ENC, pt[127:64], pt[63:0]);
      queue_request(MODE_DEC, ct[127:64], ct[63:0]);
      ct = {$urandom, $urandom, $urandom, $urandom};
      pt = spn_cipher(MODE_DEC, ct, '0);
      queue_request(MODE_DEC, ct[127:64], ct[63:0]);
      queue_request(MODE_ENC, pt[127:64], pt[63:0]);
      wait_drained();

      // random requests under a series of keys, extremes first
      for (int ph = 0; ph < KEY_PHASES; ph++) begin
         case (ph)
            0: begin klo = '1; khi = '1; end
            1: begin klo = '1; khi = '0; end
            2: begin klo = '0; khi = '1; end
            default: begin klo = pick_half(); khi = pick_half(); end
         endcase
         if (ph % 2 == 0) begin
            write_key(CSR_KEY_LOW, klo);
            write_key(CSR_KEY_HIGH, khi);
         end else begin
            write_key(CSR_KEY_HIGH, khi);
            write_key(CSR_KEY_LOW, klo);
         end
         last_req = '0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i > 0 && $urandom_range(9) == 0) begin
               // undo the previous request so a true inverse pair goes through
               ct = spn_cipher(last_req.mode, {last_req.high, last_req.low},
                               {key_high_now, key_low_now});
               last_req.mode = !last_req.mode;
               last_req.high = ct[127:64];
               last_req.low  = ct[63:0];
            end else begin
               last_req.mode = 1'($urandom_range(1));
               last_req.high = pick_half();
               last_req.low  = pick_half();
            end
            queue_request(last_req.mode, last_req.high, last_req.low);
         end
         wait_drained();
      end

      // let any stray result show up before the verdict
      repeat (CIPHER_ROUNDS + 4) @(negedge clock);
      if (mismatch_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
